@@ rtl/core/api_frame_rx_deframer_defines.svh @@
// Assertion macros shared by the receive deframer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef API_FRAME_RX_DEFRAMER_DEFINES_SVH
`define API_FRAME_RX_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define AFRD_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("deframer check failed");

// Next-cycle implication, checked outside of reset.
`define AFRD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("deframer check failed");

`endif

@@ rtl/core/afrd_pkg.sv @@
// Types and constants for the API frame receive deframer.
// Depends on nothing; used by api_frame_rx_deframer.
package afrd_pkg;

   // Framing constants.
   localparam logic [7:0] DELIM_BYTE = 8'h7E;
   localparam logic [7:0] CSUM_BASE  = 8'hFF;

   // Result kind codes.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // Parser phase.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_TYPE   = 3'd3,
      PH_DATA   = 3'd4,
      PH_CSUM   = 3'd5
   } phase_type;

endpackage

@@ rtl/core/api_frame_rx_deframer.sv @@
// Top level of the API frame receive deframer: byte stream in, payload/end results out.
// Depends on afrd_pkg and api_frame_rx_deframer_defines.svh.
//
// Usage:
//   The req channel carries one received serial byte per transaction. Bytes are
//   dropped until the 0x7E delimiter; then a big-endian 16-bit length, a frame
//   type byte, the payload bytes and a checksum byte follow. Each payload byte
//   produces one rsp transaction (tuser = 0, tlast on the final payload byte);
//   the checksum byte produces one end transaction (tuser = 1) that reports
//   whether the checksum matched. Header bytes produce no result.
//   Pipeline: an accepted byte waits in the input register, is parsed from
//   there, and its result is loaded into the result register that drives rsp
//   (one input register, one result register).
//   Throughput: one byte per cycle while rsp_tready does not hold a result; the
//   parser state updates as each byte passes from the input register onward.
//   Reset: synchronous and active high; the parser returns to delimiter
//   hunting and both pipeline registers are emptied.
//   Stall: while rsp_tready is low the pending result holds. The input register
//   still drains bytes that produce no result, and one more byte is taken
//   before req_tready drops.
module api_frame_rx_deframer (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] frame_type, [15:8] payload_byte,
                                    // [16] checksum_ok, [32:17] frame_length, rest zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // last_payload
);

   `include "api_frame_rx_deframer_defines.svh"

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;

   // Parser state.
   afrd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] decl_len_ff,  decl_len_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  cur_type_ff,  cur_type_in;
   logic [7:0]  run_sum_ff,   run_sum_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff,  out_kind_in;
   logic [7:0]  out_type_ff,  out_type_in;
   logic [7:0]  out_pay_ff,   out_pay_in;
   logic        out_last_ff,  out_last_in;
   logic        out_ok_ff,    out_ok_in;
   logic [15:0] out_len_ff,   out_len_in;

   logic        produce;
   logic        advance;
   logic [15:0] left_dec;
   logic [7:0]  sum_add;
   logic [7:0]  csum_want;

   // A byte that yields a result needs room in the result register.
   always_comb begin
      produce = (phase_ff == afrd_pkg::PH_DATA) || (phase_ff == afrd_pkg::PH_CSUM);
      advance = in_valid_ff && (!produce || !out_valid_ff || rsp_tready);
   end

   assign req_tready = !in_valid_ff || advance;

   // Input register load.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Parser next state and result formation.
   always_comb begin
      left_dec  = bytes_left_ff - 16'd1;
      sum_add   = run_sum_ff + in_byte_ff;
      csum_want = afrd_pkg::CSUM_BASE - run_sum_ff;

      phase_in      = phase_ff;
      decl_len_in   = decl_len_ff;
      bytes_left_in = bytes_left_ff;
      cur_type_in   = cur_type_ff;
      run_sum_in    = run_sum_ff;

      out_kind_in = afrd_pkg::KIND_PAYLOAD;
      out_type_in = cur_type_ff;
      out_pay_in  = 8'd0;
      out_last_in = 1'b0;
      out_ok_in   = 1'b0;
      out_len_in  = decl_len_ff;

      if (advance) begin
         unique case (phase_ff)
            afrd_pkg::PH_LEN_HI: begin
               decl_len_in = {in_byte_ff, 8'd0};
               phase_in    = afrd_pkg::PH_LEN_LO;
            end
            afrd_pkg::PH_LEN_LO: begin
               decl_len_in   = {decl_len_ff[15:8], in_byte_ff};
               // A zero length counts the type byte alone.
               bytes_left_in = ({decl_len_ff[15:8], in_byte_ff} == 16'd0) ?
                               16'd1 : {decl_len_ff[15:8], in_byte_ff};
               phase_in      = afrd_pkg::PH_TYPE;
            end
            afrd_pkg::PH_TYPE: begin
               cur_type_in   = in_byte_ff;
               run_sum_in    = in_byte_ff;
               bytes_left_in = left_dec;
               phase_in      = (left_dec == 16'd0) ? afrd_pkg::PH_CSUM : afrd_pkg::PH_DATA;
            end
            afrd_pkg::PH_DATA: begin
               run_sum_in    = sum_add;
               bytes_left_in = left_dec;
               out_pay_in    = in_byte_ff;
               out_last_in   = (left_dec == 16'd0);
               if (left_dec == 16'd0) begin
                  phase_in = afrd_pkg::PH_CSUM;
               end
            end
            afrd_pkg::PH_CSUM: begin
               out_kind_in = afrd_pkg::KIND_END;
               out_ok_in   = (in_byte_ff == csum_want);
               phase_in    = afrd_pkg::PH_IDLE;
            end
            default: begin
               // Idle and unused codes hunt for the delimiter.
               if (in_byte_ff == afrd_pkg::DELIM_BYTE) begin
                  phase_in      = afrd_pkg::PH_LEN_HI;
                  bytes_left_in = 16'd0;
                  run_sum_in    = 8'd0;
               end else begin
                  phase_in = afrd_pkg::PH_IDLE;
               end
            end
         endcase
      end
   end

   // Result register valid.
   always_comb begin
      if (advance && produce) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= afrd_pkg::PH_IDLE;
         decl_len_ff   <= 16'd0;
         bytes_left_ff <= 16'd0;
         cur_type_ff   <= 8'd0;
         run_sum_ff    <= 8'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
         decl_len_ff   <= decl_len_in;
         bytes_left_ff <= bytes_left_in;
         cur_type_ff   <= cur_type_in;
         run_sum_ff    <= run_sum_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (advance && produce) begin
         out_kind_ff <= out_kind_in;
         out_type_ff <= out_type_in;
         out_pay_ff  <= out_pay_in;
         out_last_ff <= out_last_in;
         out_ok_ff   <= out_ok_in;
         out_len_ff  <= out_len_in;
      end
   end

   // Result channel.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_len_ff, out_ok_ff, out_pay_ff, out_type_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // Checks.
   `AFRD_ASSERT_NEXT(a_rsp_held, clock, reset, out_valid_ff && !rsp_tready, out_valid_ff)
   `AFRD_ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !advance,
                     in_valid_ff && $stable(in_byte_ff))
   `AFRD_ASSERT_NEXT(a_csum_closes, clock, reset,
                     advance && (phase_ff == afrd_pkg::PH_CSUM),
                     (phase_ff == afrd_pkg::PH_IDLE) && out_valid_ff && out_kind_ff)
   `AFRD_ASSERT_NOW(a_end_not_last, clock, reset, out_valid_ff && out_kind_ff,
                    !out_last_ff && (out_pay_ff == 8'd0))

endmodule
